// ===== hw/rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Types and constants shared by the RTP receiver statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

  localparam int unsigned SeqW     = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned RateW    = 20;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned JitW     = 36;
  localparam int unsigned ProdW    = RateW + TimeW;
  // rate product plus rounding term, padded to whole bytes
  localparam int unsigned DvdW     = 72;
  localparam int unsigned DigW     = 8;
  localparam int unsigned RecipW   = 29;
  localparam int unsigned RecipSh  = 48;
  localparam int unsigned CntW     = 7;
  localparam int unsigned AddrW    = 3;

  localparam logic [RateW-1:0]  UsPerSecond     = 20'd1000000;
  localparam logic [DvdW-1:0]   HalfUsPerSecond = 72'd500000;
  // ceil(2^48 / 1e6), exact quotient for dividends below 2^28
  localparam logic [RecipW-1:0] UsRecip         = 29'd281474977;
  localparam logic [SeqW-1:0]   FirstCycle      = 16'h0001;
  localparam logic [SeqW-1:0]   HalfSeqRange    = 16'h8000;
  localparam logic [7:0]        LossSaturated   = 8'd255;

  localparam logic [CntW-1:0]   MulLast  = 7'(RateW - 1);
  // a quotient step and a remainder step for each of the nine quotient bytes
  localparam logic [CntW-1:0]   DivLast  = 7'd17;
  localparam logic [CntW-1:0]   LossLast = 7'd7;

  localparam logic [AddrW-1:0]  RegDropRepair = 3'd0;

  typedef struct packed {
    logic             action;
    logic [15:0]      seq_number;
    logic [31:0]      rtp_timestamp;
    logic [19:0]      clock_rate;
    logic             marker;
    logic             is_repair;
    logic [47:0]      arrival_time_us;
  } in_t;

  typedef struct packed {
    logic             counted;
    logic [31:0]      extended_max_seq;
    logic [31:0]      packets_received;
    logic [31:0]      jitter;
    logic [7:0]       loss_fraction;
    logic             loss_valid;
  } out_t;

  typedef enum logic [1:0] {
    CMD_PKT,
    CMD_DROP,
    CMD_CLOSE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             jit_en;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [19:0]      rate;
    logic [47:0]      t_us;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtp_receiver_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// rtp_receiver_statistics_unit
// RTP receiver sequence, loss fraction and interarrival jitter tracking.
// ----------------------------------------------------------------------------
// paths: plain packets, dropped repair packets and trivial close intervals
//   go straight to the output state; a close interval that divides runs the
//   serial loss division, and a marker packet with a clock rate runs the
//   multiply, divide and jitter states
// throughput: one transaction at a time in the back end; the serial
//   multiply and byte-wise divide by 1e6 set the jitter case
// reset: asynchronous, all statistics cleared, next packet treated as first
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_receiver_statistics_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rrs_pkg::in_t                in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output rrs_pkg::out_t                    out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrs_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic          drop_repair_q;
  logic          cmd_valid, cmd_ready;
  rrs_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == rrs_pkg::RegDropRepair) ? {31'd0, drop_repair_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_repair_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == rrs_pkg::RegDropRepair)) begin
      drop_repair_q <= pwdata[0];
    end
  end

  rrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .drop_repair_i (drop_repair_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  rrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rrs_front.sv =====
// ----------------------------------------------------------------------------
// rrs_front
// Accepts input transactions, classifies them and queues commands (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          drop_repair_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rrs_pkg::in_t  in_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output rrs_pkg::cmd_t      cmd_o
);

  rrs_pkg::cmd_t fifo_q [2];
  rrs_pkg::cmd_t cmd_new;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;

  always_comb begin
    cmd_new.kind   = rrs_pkg::CMD_PKT;
    if (in_i.action) begin
      cmd_new.kind = rrs_pkg::CMD_CLOSE;
    end else if (drop_repair_i && in_i.is_repair) begin
      cmd_new.kind = rrs_pkg::CMD_DROP;
    end
    cmd_new.jit_en = in_i.marker && (in_i.clock_rate != '0);
    cmd_new.seq    = in_i.seq_number;
    cmd_new.ts     = in_i.rtp_timestamp;
    cmd_new.rate   = in_i.clock_rate;
    cmd_new.t_us   = in_i.arrival_time_us;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rrs_back.sv =====
// ----------------------------------------------------------------------------
// rrs_back
// Executes commands: sequence tracking, serial rate conversion, jitter and
// serial loss fraction; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire rrs_pkg::cmd_t  cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rrs_pkg::out_t       out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_JIT,
    S_LOSS,
    S_OUT
  } state_e;

  state_e                           state_q;
  logic                             awaiting_q;
  logic [31:0]                      max_q, start_q, icount_q, total_q, prev_q;
  logic [rrs_pkg::JitW-1:0]         jq_q;
  logic [rrs_pkg::DvdW-1:0]         acc_q;
  logic [rrs_pkg::ProdW-1:0]        mcand_q;
  logic [rrs_pkg::RateW-1:0]        mult_q, rem_q;
  logic [31:0]                      quo_q, ts_q, lrem_q, exp_q;
  logic [rrs_pkg::DigW-1:0]         qd_q;
  logic [rrs_pkg::CntW-1:0]         cnt_q;
  logic                             counted_q, lvalid_q;
  logic [7:0]                       loss_q;
  logic                             out_valid_q;
  rrs_pkg::out_t                    out_q;

  // packet sequence update
  logic [31:0] base_max, new_max;
  logic [15:0] old_seq, diff;
  logic        newer;
  // close interval
  logic [31:0] expected, lost;
  // division steps
  logic [rrs_pkg::RateW+rrs_pkg::DigW-1:0] dvd_x, q_back;
  logic [55:0]                             q_prod;
  logic [32:0]                             lrem2;
  // jitter
  logic [31:0] transit, prev_eff, dlt, adlt;
  logic [rrs_pkg::JitW:0] jq_rnd;
  logic        load_out;

  always_comb begin
    base_max = awaiting_q ? {rrs_pkg::FirstCycle, cmd_i.seq} : max_q;
    old_seq  = base_max[15:0];
    diff     = cmd_i.seq - old_seq;
    if (diff == rrs_pkg::HalfSeqRange) begin
      newer = cmd_i.seq > old_seq;
    end else begin
      newer = (diff != '0) && !diff[15];
    end
    new_max = base_max;
    if (newer) begin
      new_max = {16'(base_max[31:16] + {15'd0, cmd_i.seq < old_seq}), cmd_i.seq};
    end
    expected = max_q - start_q;
    lost     = expected - icount_q;
    dvd_x    = {rem_q, acc_q[rrs_pkg::DvdW-1 -: rrs_pkg::DigW]};
    q_prod   = 56'(dvd_x) * 56'(rrs_pkg::UsRecip);
    q_back   = 28'(qd_q) * 28'(rrs_pkg::UsPerSecond);
    lrem2    = {lrem_q, 1'b0};
    transit  = quo_q - ts_q;
    prev_eff = (prev_q == '0) ? transit : prev_q;
    dlt      = transit - prev_eff;
    adlt     = dlt[31] ? 32'(-dlt) : dlt;
    jq_rnd   = {1'b0, jq_q} + 37'd8;
    load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      awaiting_q  <= 1'b1;
      max_q       <= '0;
      start_q     <= '0;
      icount_q    <= '0;
      total_q     <= '0;
      prev_q      <= '0;
      jq_q        <= '0;
      acc_q       <= '0;
      mcand_q     <= '0;
      mult_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      ts_q        <= '0;
      lrem_q      <= '0;
      exp_q       <= '0;
      qd_q        <= '0;
      cnt_q       <= '0;
      counted_q   <= 1'b0;
      lvalid_q    <= 1'b0;
      loss_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cnt_q <= '0;
            unique case (cmd_i.kind)
              rrs_pkg::CMD_CLOSE: begin
                counted_q <= 1'b0;
                lvalid_q  <= 1'b1;
                icount_q  <= '0;
                start_q   <= max_q;
                lrem_q    <= lost;
                exp_q     <= expected;
                if ((expected != '0) && !lost[31] && (lost < expected)) begin
                  loss_q  <= '0;
                  state_q <= S_LOSS;
                end else if ((expected != '0) && !lost[31]) begin
                  loss_q  <= rrs_pkg::LossSaturated;
                  state_q <= S_OUT;
                end else begin
                  loss_q  <= '0;
                  state_q <= S_OUT;
                end
              end
              rrs_pkg::CMD_PKT: begin
                counted_q  <= newer;
                lvalid_q   <= 1'b0;
                loss_q     <= '0;
                awaiting_q <= 1'b0;
                if (awaiting_q) begin
                  start_q <= base_max;
                end
                max_q <= new_max;
                if (newer) begin
                  icount_q <= icount_q + 32'd1;
                  total_q  <= total_q + 32'd1;
                end
                if (cmd_i.jit_en) begin
                  acc_q   <= rrs_pkg::HalfUsPerSecond;
                  mcand_q <= rrs_pkg::ProdW'(cmd_i.t_us);
                  mult_q  <= cmd_i.rate;
                  ts_q    <= cmd_i.ts;
                  state_q <= S_MUL;
                end else begin
                  state_q <= S_OUT;
                end
              end
              default: begin
                counted_q <= 1'b0;
                lvalid_q  <= 1'b0;
                loss_q    <= '0;
                state_q   <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          if (mult_q[0]) begin
            acc_q <= acc_q + rrs_pkg::DvdW'(mcand_q);
          end
          mcand_q <= {mcand_q[rrs_pkg::ProdW-2:0], 1'b0};
          mult_q  <= {1'b0, mult_q[rrs_pkg::RateW-1:1]};
          if (cnt_q == rrs_pkg::MulLast) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_DIV: begin
          // byte-wise long division by 1e6: quotient byte, then remainder
          if (!cnt_q[0]) begin
            qd_q <= q_prod[rrs_pkg::RecipSh +: rrs_pkg::DigW];
          end else begin
            rem_q <= rrs_pkg::RateW'(dvd_x - q_back);
            quo_q <= {quo_q[23:0], qd_q};
            acc_q <= {acc_q[rrs_pkg::DvdW-rrs_pkg::DigW-1:0], 8'd0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == rrs_pkg::DivLast) begin
            state_q <= S_JIT;
          end
        end
        S_JIT: begin
          prev_q  <= transit;
          jq_q    <= rrs_pkg::JitW'(jq_q + rrs_pkg::JitW'(adlt) - jq_rnd[rrs_pkg::JitW:4]);
          state_q <= S_OUT;
        end
        S_LOSS: begin
          if (lrem2 >= {1'b0, exp_q}) begin
            lrem_q <= 32'(lrem2 - {1'b0, exp_q});
            loss_q <= {loss_q[6:0], 1'b1};
          end else begin
            lrem_q <= lrem2[31:0];
            loss_q <= {loss_q[6:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == rrs_pkg::LossLast) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_q.counted          <= counted_q;
            out_q.extended_max_seq <= max_q;
            out_q.packets_received <= total_q;
            out_q.jitter           <= jq_q[rrs_pkg::JitW-1:4];
            out_q.loss_fraction    <= loss_q;
            out_q.loss_valid       <= lvalid_q;
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
